### hdl/amiu_pkg.sv
`default_nettype none
package amiu_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned N_FIELD = 12;
  localparam int unsigned PROD_W  = 2 * FIELD_W;
  localparam int unsigned COF_W   = PROD_W + 1;
  localparam int unsigned PP_W    = 2 * FIELD_W + 1;
  localparam int unsigned CP_W    = COF_W + FIELD_W;
  localparam int unsigned DET_W   = CP_W + 3;
  localparam int unsigned Q_W     = FIELD_W;

  typedef logic [3:0] idx_t;

  // adjugate entry (row, col) = cofactor (col, row) = m[p]*m[q] - m[r]*m[s], m indexed row*3+col
  localparam idx_t COF_TAB [9][4] = '{
    '{4'd8, 4'd4, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd8, 4'd1}, '{4'd5, 4'd1, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd8, 4'd3}, '{4'd8, 4'd0, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd5, 4'd0},
    '{4'd7, 4'd3, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd7, 4'd0}, '{4'd4, 4'd0, 4'd1, 4'd3}
  };

endpackage
`default_nettype wire

### hdl/amiu_div.sv
`default_nettype none
module amiu_div #(
  parameter int NW = 133,
  parameter int DW = 100
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [NW-1:0]            num,
  input  wire logic signed [DW-1:0]            den,
  input  wire logic                            zero,
  output logic [amiu_pkg::Q_W-1:0]             quo
);
  import amiu_pkg::*;

  localparam int RW = NW + DW;

  logic [NW-1:0] nm_r;
  logic [DW-1:0] dm_r;
  logic          neg_r, zr_r;

  logic [RW-1:0]  r_r   [0:Q_W-1];
  logic [DW-1:0]  d_r   [0:Q_W-1];
  logic [Q_W-1:0] q_r   [0:Q_W];
  logic           ovf_r [0:Q_W];
  logic           sg_r  [0:Q_W];
  logic           z_r   [0:Q_W];
  logic [Q_W-1:0] quo_r;

  logic [Q_W-1:0] qf;
  logic           pos_sat, neg_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      dm_r  <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_r <= num[NW-1] ^ den[DW-1];
      zr_r  <= zero;
      r_r[0]   <= RW'(nm_r);
      d_r[0]   <= dm_r;
      ovf_r[0] <= RW'(nm_r) >= (RW'(dm_r) << Q_W);
      sg_r[0]  <= neg_r;
      z_r[0]   <= zr_r;
      q_r[0]   <= '0;
    end
  end

  // one quotient bit a stage, most significant first
  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int K = Q_W - 1 - i;
    logic [RW:0] diff;
    assign diff = {1'b0, r_r[i]} - {1'b0, (RW'(d_r[i]) << K)};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]   <= diff[RW] ? q_r[i] : (q_r[i] | (Q_W'(1) << K));
        ovf_r[i+1] <= ovf_r[i];
        sg_r[i+1]  <= sg_r[i];
        z_r[i+1]   <= z_r[i];
      end
    end
    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[i+1] <= diff[RW] ? r_r[i] : diff[RW-1:0];
          d_r[i+1] <= d_r[i];
        end
      end
    end
  end

  assign qf      = q_r[Q_W];
  assign pos_sat = ovf_r[Q_W] | qf[Q_W-1];
  assign neg_sat = ovf_r[Q_W] | (qf[Q_W-1] & (|qf[Q_W-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_r[Q_W]) begin
        quo_r <= '0;
      end else if (!sg_r[Q_W]) begin
        quo_r <= pos_sat ? {1'b0, {(Q_W-1){1'b1}}} : qf;
      end else begin
        quo_r <= neg_sat ? {1'b1, {(Q_W-1){1'b0}}} : Q_W'(-qf);
      end
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

### hdl/affine_matrix_inverse_unit.sv
`default_nettype none
// Inverts one 3x4 affine matrix (columns x, y, z, translation; bottom row 0,0,0,1)
// of signed fixed-point entries with FRAC_BITS fraction bits. The nine
// cofactors, the determinant and the translation dot products are formed
// exactly; each of the twelve results is one truncating division by the
// determinant, saturated to 32 bits, and a singular matrix gives all zeros.
// A matrix is accepted every cycle while the output is not stalled. Each passes
// six stages of multiply and add, then a restoring divider per result that
// settles one quotient bit a stage. A stalled output holds the whole pipeline.
module affine_matrix_inverse_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a00,a01,a02,a03,a10,a11,a12,a13,a20,a21,a22,a23, 32 bits each, lowest first
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // b00,b01,b02,b03,b10,b11,b12,b13,b20,b21,b22,b23, 32 bits each, lowest first
  output logic [383:0]      out_tdata
);
  import amiu_pkg::*;

  localparam int NW  = 101 + 2 * FRAC_BITS;
  localparam int LAT = 6 + Q_W + 3;

  logic            en;
  logic [LAT-1:0]  v_r;

  logic signed [FIELD_W-1:0] m_in [0:8];
  logic signed [FIELD_W-1:0] t_in [0:2];

  logic signed [PROD_W-1:0]  p1_r [0:17];
  logic signed [FIELD_W-1:0] m1_r [0:2], t1_r [0:2];
  logic signed [COF_W-1:0]   c2_r [0:8];
  logic signed [FIELD_W-1:0] m2_r [0:2], t2_r [0:2];
  logic signed [PP_W-1:0]    lo3_r [0:11], hi3_r [0:11];
  logic signed [COF_W-1:0]   c3_r [0:8], c4_r [0:8], c5_r [0:8];
  logic signed [CP_W-1:0]    cp4_r [0:11];
  logic signed [DET_W-1:0]   det5_r, s5_r [0:2];
  logic signed [NW-1:0]      nc6_r [0:8], nt6_r [0:2];
  logic signed [DET_W-1:0]   det6_r;
  logic                      z6_r;

  logic signed [COF_W-1:0]   mul_c [0:11];
  logic signed [FIELD_W-1:0] mul_x [0:11];

  assign en         = !v_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign m_in[i*3+j] = in_tdata[FIELD_W*(i*4+j) +: FIELD_W];
    end
    assign t_in[i] = in_tdata[FIELD_W*(i*4+3) +: FIELD_W];
  end

  // stage 1: the eighteen products of the cofactors
  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[2*k]   <= m_in[COF_TAB[k][0]] * m_in[COF_TAB[k][1]];
        p1_r[2*k+1] <= m_in[COF_TAB[k][2]] * m_in[COF_TAB[k][3]];
        c2_r[k]     <= COF_W'(p1_r[2*k]) - COF_W'(p1_r[2*k+1]);
        c3_r[k]     <= c2_r[k];
        c4_r[k]     <= c3_r[k];
        c5_r[k]     <= c4_r[k];
        nc6_r[k]    <= NW'(c5_r[k]) <<< (2 * FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m_in[0:2];
      t1_r <= t_in;
      m2_r <= m1_r;
      t2_r <= t1_r;
    end
  end

  // stage 3: cofactor times entry, split into two narrow partial products
  for (genvar j = 0; j < 3; j++) begin : g_detp
    assign mul_c[j] = c2_r[3*j];
    assign mul_x[j] = m2_r[j];
    for (genvar i = 0; i < 3; i++) begin : g_trp
      assign mul_c[3+i*3+j] = c2_r[i*3+j];
      assign mul_x[3+i*3+j] = t2_r[j];
    end
  end

  for (genvar k = 0; k < 12; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        lo3_r[k] <= $signed({1'b0, mul_c[k][FIELD_W-1:0]}) * mul_x[k];
        hi3_r[k] <= $signed(mul_c[k][COF_W-1:FIELD_W]) * mul_x[k];
        cp4_r[k] <= (CP_W'(hi3_r[k]) <<< FIELD_W) + CP_W'(lo3_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det5_r <= DET_W'(cp4_r[0]) + DET_W'(cp4_r[1]) + DET_W'(cp4_r[2]);
      for (int i = 0; i < 3; i++) begin
        s5_r[i] <= DET_W'(cp4_r[3+i*3]) + DET_W'(cp4_r[4+i*3]) + DET_W'(cp4_r[5+i*3]);
        nt6_r[i] <= (-NW'(s5_r[i])) <<< FRAC_BITS;
      end
      det6_r <= det5_r;
      z6_r   <= det5_r == '0;
    end
  end

  for (genvar k = 0; k < N_FIELD; k++) begin : g_div
    localparam int R = k / 4;
    localparam int C = k % 4;
    logic signed [NW-1:0] num;
    if (C < 3) begin : g_lin
      assign num = nc6_r[R*3+C];
    end else begin : g_tr
      assign num = nt6_r[R];
    end
    amiu_div #(.NW(NW), .DW(DET_W)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (num),
      .den  (det6_r),
      .zero (z6_r),
      .quo  (out_tdata[Q_W*k +: Q_W])
    );
  end

endmodule
`default_nettype wire

### hdl/amiu_checker.sv
`default_nettype none
module amiu_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [383:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed under stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with empty output");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind affine_matrix_inverse_unit amiu_checker u_amiu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### test/affine_matrix_inverse_unit_tb.sv
module affine_matrix_inverse_unit_tb;
  import amiu_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 41;
  localparam int N_RANDOM = 1900;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [31:0] fixed_t;
  // wide enough for a shifted cofactor times a translation, plus sign
  typedef logic signed [191:0] wide_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [383:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [383:0] out_tdata;

  int errors;
  longint cycles;

  affine_matrix_inverse_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  function automatic fixed_t div_saturate(wide_t num, wide_t den);
    wide_t q;
    q = num / den;
    if (q > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (q < -64'sh80000000) return 32'sh80000000;
    return fixed_t'(q[31:0]);
  endfunction

  function automatic logic [383:0] invert_affine(logic [383:0] packed_in);
    wide_t m [9];
    wide_t t [3];
    wide_t cof [9];
    wide_t det;
    wide_t dot;
    logic [383:0] res;
    res = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r * 3 + c] = wide_t'($signed(packed_in[(r * 4 + c) * 32 +: 32]));
      end
      t[r] = wide_t'($signed(packed_in[(r * 4 + 3) * 32 +: 32]));
    end
    // adjugate entry (i,j) = cofactor (j,i) = m[p]*m[q] - m[r]*m[s]
    cof[0] = m[8] * m[4] - m[5] * m[7];
    cof[1] = m[2] * m[7] - m[8] * m[1];
    cof[2] = m[5] * m[1] - m[2] * m[4];
    cof[3] = m[5] * m[6] - m[8] * m[3];
    cof[4] = m[8] * m[0] - m[2] * m[6];
    cof[5] = m[2] * m[3] - m[5] * m[0];
    cof[6] = m[7] * m[3] - m[4] * m[6];
    cof[7] = m[1] * m[6] - m[7] * m[0];
    cof[8] = m[4] * m[0] - m[1] * m[3];
    det = cof[0] * m[0] + cof[3] * m[1] + cof[6] * m[2];
    if (det == 0) return res;
    for (int i = 0; i < 3; i++) begin
      dot = 0;
      for (int j = 0; j < 3; j++) begin
        res[(i * 4 + j) * 32 +: 32] = div_saturate(cof[i * 3 + j] <<< (2 * FRAC), det);
        dot = dot + cof[i * 3 + j] * t[j];
      end
      res[(i * 4 + 3) * 32 +: 32] = div_saturate((-dot) <<< FRAC, det);
    end
    return res;
  endfunction

  class inverse_scoreboard;
    logic [383:0] pending_inverses [$];
    int fail_count;

    function void note_matrix(logic [383:0] mat);
      pending_inverses.push_back(invert_affine(mat));
    endfunction

    function void check_inverse(logic [383:0] got);
      logic [383:0] want;
      if (pending_inverses.size() == 0) begin
        $error("unexpected result word %h", got);
        fail_count++;
        return;
      end
      want = pending_inverses.pop_front();
      for (int k = 0; k < 12; k++) begin
        if (want[k * 32 +: 32] !== got[k * 32 +: 32]) begin
          $error("b%0d%0d: expected %0d, got %0d", k / 4, k % 4,
                 $signed(want[k * 32 +: 32]), $signed(got[k * 32 +: 32]));
          fail_count++;
        end
      end
    endfunction
  endclass

  inverse_scoreboard sb;
  logic [383:0] directed_q [$];
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      4, 5: return $urandom;
      default: return $unsigned($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
    endcase
  endfunction

  function automatic logic [383:0] rand_matrix();
    logic [383:0] mat;
    int r;
    for (int k = 0; k < 12; k++) mat[k * 32 +: 32] = rand_entry();
    // make some singular by copying one row onto another
    if ($urandom_range(0, 15) == 0) begin
      r = $urandom_range(1, 2);
      for (int c = 0; c < 3; c++) mat[(r * 4 + c) * 32 +: 32] = mat[c * 32 +: 32];
    end
    return mat;
  endfunction

  // valid stays high after the handshake; drop it only when idling
  task automatic send_matrix(logic [383:0] mat);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mat;
    do @(posedge clk); while (!in_tready);
    sb.note_matrix(mat);
  endtask

  task automatic build_directed();
    logic [383:0] mat;
    int vals [4];
    vals = '{32'h00010000, 32'h7FFFFFFF, 32'h80000000, 32'h00000001};
    for (int v = 0; v < 4; v++) begin
      // scaled identity with translation extremes
      mat = '0;
      for (int i = 0; i < 3; i++) mat[(i * 5) * 32 +: 32] = vals[v];
      mat[3 * 32 +: 32] = 32'h7FFFFFFF;
      mat[7 * 32 +: 32] = 32'h80000000;
      mat[11 * 32 +: 32] = 32'hFFFFFFFF;
      directed_q.push_back(mat);
    end
    directed_q.push_back('0);
    directed_q.push_back({12{32'hFFFFFFFF}});
    directed_q.push_back({12{32'h80000000}});
    directed_q.push_back({12{32'h7FFFFFFF}});
    directed_q.push_back({12{32'h55555555}});
    directed_q.push_back({12{32'hAAAAAAAA}});
    for (int k = 0; k < 10; k++) directed_q.push_back(rand_matrix());
  endtask

  initial begin
    sb = new();
    errors = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    build_directed();
    foreach (directed_q[k]) send_matrix(directed_q[k]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // drain everything before carrying on
        in_tvalid <= 1'b0;
        while (sb.pending_inverses.size() != 0) @(posedge clk);
      end
      send_matrix(rand_matrix());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls, with runs of no stall
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_inverse(out_tdata);
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    errors = sb.fail_count + sb.pending_inverses.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### affine_matrix_inverse_unit.f
hdl/amiu_pkg.sv
hdl/amiu_div.sv
hdl/affine_matrix_inverse_unit.sv
hdl/amiu_checker.sv
test/affine_matrix_inverse_unit_tb.sv
